// ===== design/pscnt_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet statistics package
// Operation codes, counter numbers, descriptor and bucket types, and the
// per-counter increment rule shared by the statistics block.
// ----------------------------------------------------------------------------
package pscnt_pkg;

  typedef enum logic [2:0] {
    OP_RECORD   = 3'd0,
    OP_READ_CNT = 3'd1,
    OP_WINDOW   = 3'd2,
    OP_PEAK     = 3'd3,
    OP_PORT     = 3'd4
  } pscnt_op_t;

  localparam int NUM_COUNTERS = 23;

  localparam logic [4:0] C_PKTS   = 5'd0;
  localparam logic [4:0] C_BYTES  = 5'd1;
  localparam logic [4:0] C_TRUNC  = 5'd2;
  localparam logic [4:0] C_BADCK  = 5'd3;
  localparam logic [4:0] C_FRAG   = 5'd4;
  localparam logic [4:0] C_DECERR = 5'd5;
  localparam logic [4:0] C_IPV4   = 5'd6;
  localparam logic [4:0] C_IPV6   = 5'd7;
  localparam logic [4:0] C_ARP_P  = 5'd8;
  localparam logic [4:0] C_ARP_B  = 5'd9;
  localparam logic [4:0] C_TCP_P  = 5'd10;
  localparam logic [4:0] C_TCP_B  = 5'd11;
  localparam logic [4:0] C_SYN    = 5'd12;
  localparam logic [4:0] C_FIN    = 5'd13;
  localparam logic [4:0] C_RST    = 5'd14;
  localparam logic [4:0] C_UDP_P  = 5'd15;
  localparam logic [4:0] C_UDP_B  = 5'd16;
  localparam logic [4:0] C_ICMP_P = 5'd17;
  localparam logic [4:0] C_ICMP_B = 5'd18;
  localparam logic [4:0] C_OTH_P  = 5'd19;
  localparam logic [4:0] C_OTH_B  = 5'd20;
  localparam logic [4:0] C_FIRST  = 5'd21;
  localparam logic [4:0] C_LAST   = 5'd22;

  localparam int FLG_TRUNC  = 0;
  localparam int FLG_BADCK  = 1;
  localparam int FLG_FRAG   = 2;
  localparam int FLG_DECERR = 3;
  localparam int FLG_PORTS  = 4;

  localparam logic [1:0] L3_IPV4 = 2'd1;
  localparam logic [1:0] L3_IPV6 = 2'd2;
  localparam logic [1:0] L3_ARP  = 2'd3;

  localparam logic [2:0] L4_TCP    = 3'd1;
  localparam logic [2:0] L4_UDP    = 3'd2;
  localparam logic [2:0] L4_ICMP   = 3'd3;
  localparam logic [2:0] L4_ICMPV6 = 3'd4;

  localparam int TCP_FIN = 0;
  localparam int TCP_SYN = 1;
  localparam int TCP_RST = 2;

  typedef struct packed {
    logic [31:0] ts_sec;
    logic [15:0] wire_len;
    logic [4:0]  status_flags;
    logic [1:0]  l3_kind;
    logic [2:0]  l4_kind;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] select;
  } pscnt_desc_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [63:0] pkts;
    logic [63:0] bytes;
  } pscnt_bkt_t;

  // Amount added to one counter by a recorded packet.
  function automatic logic [15:0] counter_inc(logic [4:0] idx, pscnt_desc_t d);
    logic dec;
    logic arp;
    logic cls;
    logic tcp;
    logic udp;
    logic icmp;
    logic oth;
    logic [15:0] one;
    logic [15:0] len;
    logic [15:0] inc;
    dec  = d.status_flags[FLG_DECERR];
    arp  = !dec && (d.l3_kind == L3_ARP);
    cls  = !dec && !arp;
    tcp  = cls && (d.l4_kind == L4_TCP);
    udp  = cls && (d.l4_kind == L4_UDP);
    icmp = cls && ((d.l4_kind == L4_ICMP) || (d.l4_kind == L4_ICMPV6));
    oth  = cls && !tcp && !udp && !icmp;
    one  = 16'd1;
    len  = d.wire_len;
    case (idx)
      C_PKTS:   inc = one;
      C_BYTES:  inc = len;
      C_TRUNC:  inc = d.status_flags[FLG_TRUNC] ? one : '0;
      C_BADCK:  inc = d.status_flags[FLG_BADCK] ? one : '0;
      C_FRAG:   inc = d.status_flags[FLG_FRAG] ? one : '0;
      C_DECERR: inc = dec ? one : '0;
      C_IPV4:   inc = (!dec && d.l3_kind == L3_IPV4) ? one : '0;
      C_IPV6:   inc = (!dec && d.l3_kind == L3_IPV6) ? one : '0;
      C_ARP_P:  inc = arp ? one : '0;
      C_ARP_B:  inc = arp ? len : '0;
      C_TCP_P:  inc = tcp ? one : '0;
      C_TCP_B:  inc = tcp ? len : '0;
      C_SYN:    inc = (tcp && d.tcp_flag_bits[TCP_SYN]) ? one : '0;
      C_FIN:    inc = (tcp && d.tcp_flag_bits[TCP_FIN]) ? one : '0;
      C_RST:    inc = (tcp && d.tcp_flag_bits[TCP_RST]) ? one : '0;
      C_UDP_P:  inc = udp ? one : '0;
      C_UDP_B:  inc = udp ? len : '0;
      C_ICMP_P: inc = icmp ? one : '0;
      C_ICMP_B: inc = icmp ? len : '0;
      C_OTH_P:  inc = oth ? one : '0;
      C_OTH_B:  inc = oth ? len : '0;
      default:  inc = '0;
    endcase
    return inc;
  endfunction

endpackage

// ===== design/pscnt_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one packet descriptor or read request.
// ----------------------------------------------------------------------------
interface pscnt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] ts_sec;
  logic [15:0] wire_len;
  logic [4:0]  status_flags;
  logic [1:0]  l3_kind;
  logic [2:0]  l4_kind;
  logic [7:0]  tcp_flag_bits;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] select;

  modport source (
    output valid, operation, ts_sec, wire_len, status_flags, l3_kind, l4_kind,
           tcp_flag_bits, src_port, dst_port, select,
    input  ready
  );
  modport sink (
    input  valid, operation, ts_sec, wire_len, status_flags, l3_kind, l4_kind,
           tcp_flag_bits, src_port, dst_port, select,
    output ready
  );
endinterface

// ===== design/pscnt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the result of one read request.
// ----------------------------------------------------------------------------
interface pscnt_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic [63:0] window_packets;

  modport source (output valid, read_value, window_packets, input ready);
  modport sink (input valid, read_value, window_packets, output ready);
endinterface

// ===== design/packet_statistics_counters.sv =====
// ----------------------------------------------------------------------------
// Packet statistics counters
// Counts packets and bytes per class and per second, and bytes per port, and
// answers counter, window, peak and port reads.
// ----------------------------------------------------------------------------
// After reset the block clears its memories before the first request is
// taken. One request is handled at a time. A record keeps the block busy
// after it is accepted while it reduces the timestamp to its ring slot by
// reciprocal multiplication, does the bucket read-modify-write, does the
// read-modify-write of the 23 counters through the single port of the
// counter memory, and updates the port entry. A window read walks back one
// bucket per second covered, a peak read scans every bucket, and counter
// and port reads make one memory read each. A response waits in an output
// register until it is taken.
module packet_statistics_counters
  import pscnt_pkg::*;
#(
  parameter int WINDOW_SECONDS = 64
) (
  input  logic clk,
  input  logic rst,
  pscnt_req_if.sink   req,
  pscnt_rsp_if.source rsp
);
  localparam int SLOT_W = $clog2(WINDOW_SECONDS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SECONDS - 1);
  localparam logic [15:0] WIN_MAX = 16'(WINDOW_SECONDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD_GO, S_MOD, S_BKT_RD, S_BKT_WR, S_CNT_RD, S_CNT_WR,
    S_PORT_WR, S_WIN_RD, S_WIN_ACC, S_PEAK_RD, S_PEAK_ACC, S_PORT_RD, S_RDQ,
    S_RESULT
  } state_t;

  state_t      state;
  pscnt_desc_t d;
  pscnt_op_t   op;
  logic [15:0] clr_addr;
  logic [SLOT_W-1:0] slot;
  logic [4:0]  cidx;
  logic        pkts_zero;
  logic [31:0] newest;
  logic [31:0] win_sec;
  logic [15:0] win_left;
  logic [63:0] rv;
  logic [63:0] rp;
  logic        ovalid;
  logic [63:0] res_val;
  logic [63:0] res_pkts;

  pscnt_bkt_t bkt_mem [WINDOW_SECONDS];
  pscnt_bkt_t bkt_q;
  logic       bkt_re;
  logic       bkt_we;
  logic [SLOT_W-1:0] bkt_waddr;
  pscnt_bkt_t bkt_wdata;

  logic [63:0] cnt_mem [NUM_COUNTERS];
  logic [63:0] cnt_q;
  logic        cnt_re;
  logic        cnt_we;
  logic [4:0]  cnt_waddr;
  logic [63:0] cnt_wdata;

  logic [63:0] port_mem [65536];
  logic [63:0] port_q;
  logic        port_re;
  logic [15:0] port_raddr;
  logic        port_we;
  logic [15:0] port_waddr;
  logic [63:0] port_wdata;

  logic        mod_start;
  logic [31:0] mod_val;
  logic        mod_done;
  logic [SLOT_W-1:0] mod_rem;

  logic [15:0] svc;
  logic        port_use;
  logic        fresh;
  logic        out_load;

  pscnt_mod #(.MODULUS(WINDOW_SECONDS)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (mod_val),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    svc      = (d.src_port < d.dst_port) ? d.src_port : d.dst_port;
    port_use = d.status_flags[FLG_PORTS] && !d.status_flags[FLG_DECERR] &&
               (d.l3_kind != L3_ARP);
    fresh    = bkt_q.tag != d.ts_sec;
    out_load = (state == S_RESULT) && (!ovalid || rsp.ready);

    mod_start = state == S_MOD_GO;
    mod_val   = (op == OP_RECORD) ? d.ts_sec : newest - 32'd1;

    bkt_re    = (state == S_BKT_RD) || (state == S_WIN_RD) || (state == S_PEAK_RD);
    bkt_we    = ((state == S_CLEAR) && ({1'b0, clr_addr} < 17'(WINDOW_SECONDS))) ||
                (state == S_BKT_WR);
    bkt_waddr = (state == S_CLEAR) ? clr_addr[SLOT_W-1:0] : slot;
    if (state == S_CLEAR) begin
      bkt_wdata = '0;
    end else begin
      bkt_wdata.tag   = d.ts_sec;
      bkt_wdata.pkts  = (fresh ? 64'd0 : bkt_q.pkts) + 64'd1;
      bkt_wdata.bytes = (fresh ? 64'd0 : bkt_q.bytes) + 64'(d.wire_len);
    end

    cnt_re    = state == S_CNT_RD;
    cnt_we    = ((state == S_CLEAR) && (clr_addr < 16'(NUM_COUNTERS))) ||
                (state == S_CNT_WR);
    cnt_waddr = (state == S_CLEAR) ? clr_addr[4:0] : cidx;
    if (state == S_CLEAR) begin
      cnt_wdata = '0;
    end else begin
      case (cidx)
        C_FIRST: cnt_wdata = pkts_zero ? 64'(d.ts_sec) : cnt_q;
        C_LAST:  cnt_wdata = 64'(d.ts_sec);
        default: cnt_wdata = cnt_q + 64'(counter_inc(cidx, d));
      endcase
    end

    port_re    = (state == S_BKT_RD) || (state == S_PORT_RD);
    port_raddr = (op == OP_RECORD) ? svc : d.select;
    port_we    = (state == S_CLEAR) || ((state == S_PORT_WR) && port_use);
    port_waddr = (state == S_CLEAR) ? clr_addr : svc;
    port_wdata = (state == S_CLEAR) ? 64'd0 : port_q + 64'(d.wire_len);
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_q <= bkt_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q <= cnt_mem[cidx];
    end
  end

  always_ff @(posedge clk) begin
    if (port_we) begin
      port_mem[port_waddr] <= port_wdata;
    end
    if (port_re) begin
      port_q <= port_mem[port_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      newest   <= '0;
      ovalid   <= 1'b0;
    end else begin
      if (out_load) begin
        ovalid   <= 1'b1;
        res_val  <= rv;
        res_pkts <= rp;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 16'd1;
          if (clr_addr == 16'hFFFF) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op              <= pscnt_op_t'(req.operation);
            d.ts_sec        <= req.ts_sec;
            d.wire_len      <= req.wire_len;
            d.status_flags  <= req.status_flags;
            d.l3_kind       <= req.l3_kind;
            d.l4_kind       <= req.l4_kind;
            d.tcp_flag_bits <= req.tcp_flag_bits;
            d.src_port      <= req.src_port;
            d.dst_port      <= req.dst_port;
            d.select        <= req.select;
            rv <= '0;
            rp <= '0;
            case (req.operation)
              OP_RECORD: state <= S_MOD_GO;
              OP_READ_CNT: begin
                if (req.select < 16'(NUM_COUNTERS)) begin
                  cidx  <= req.select[4:0];
                  state <= S_CNT_RD;
                end else begin
                  state <= S_RESULT;
                end
              end
              OP_WINDOW: begin
                win_sec  <= newest - 32'd1;
                win_left <= (req.select > WIN_MAX) ? WIN_MAX : req.select;
                if (req.select == 16'd0 || newest == 32'd0) begin
                  state <= S_RESULT;
                end else begin
                  state <= S_MOD_GO;
                end
              end
              OP_PEAK: begin
                slot  <= '0;
                state <= S_PEAK_RD;
              end
              OP_PORT: state <= S_PORT_RD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MOD_GO: state <= S_MOD;
        S_MOD: begin
          if (mod_done) begin
            slot  <= mod_rem;
            state <= (op == OP_RECORD) ? S_BKT_RD : S_WIN_RD;
          end
        end
        S_BKT_RD: state <= S_BKT_WR;
        S_BKT_WR: begin
          if (d.ts_sec > newest) begin
            newest <= d.ts_sec;
          end
          cidx  <= C_PKTS;
          state <= S_CNT_RD;
        end
        S_CNT_RD: state <= (op == OP_RECORD) ? S_CNT_WR : S_RDQ;
        S_CNT_WR: begin
          if (cidx == C_PKTS) begin
            pkts_zero <= cnt_q == 64'd0;
          end
          if (cidx == C_LAST) begin
            state <= S_PORT_WR;
          end else begin
            cidx  <= cidx + 5'd1;
            state <= S_CNT_RD;
          end
        end
        S_PORT_WR: state <= S_IDLE;
        S_WIN_RD: state <= S_WIN_ACC;
        S_WIN_ACC: begin
          if (bkt_q.tag == win_sec) begin
            rv <= rv + bkt_q.bytes;
            rp <= rp + bkt_q.pkts;
          end
          if (win_left == 16'd1 || win_sec == 32'd0) begin
            state <= S_RESULT;
          end else begin
            win_left <= win_left - 16'd1;
            win_sec  <= win_sec - 32'd1;
            slot     <= (slot == '0) ? LAST_SLOT : slot - SLOT_W'(1);
            state    <= S_WIN_RD;
          end
        end
        S_PEAK_RD: state <= S_PEAK_ACC;
        S_PEAK_ACC: begin
          if (bkt_q.tag != 32'd0 && bkt_q.bytes > rv) begin
            rv <= bkt_q.bytes;
          end
          if (slot == LAST_SLOT) begin
            state <= S_RESULT;
          end else begin
            slot  <= slot + SLOT_W'(1);
            state <= S_PEAK_RD;
          end
        end
        S_PORT_RD: state <= S_RDQ;
        S_RDQ: begin
          rv    <= (op == OP_READ_CNT) ? cnt_q : port_q;
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready          = state == S_IDLE;
  assign rsp.valid          = ovalid;
  assign rsp.read_value     = res_val;
  assign rsp.window_packets = res_pkts;

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !ovalid)
    else $error("response raised during clearing pass");

  a_cnt_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_CNT_RD || state == S_CNT_WR) |-> cidx < 5'(NUM_COUNTERS))
    else $error("counter index out of range");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    bkt_re |-> {1'b0, slot} <= {1'b0, LAST_SLOT})
    else $error("bucket slot out of range");

  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> $past(state == S_MOD) && state == S_MOD)
    else $error("slot reduction finished outside its wait state");
endmodule

// ===== design/pscnt_mod.sv =====
// ----------------------------------------------------------------------------
// Bucket slot reduction
// Reduces a 32-bit second to its ring slot by reciprocal multiplication and
// one corrective subtraction; done pulses after stage1, stage2 and stage3.
// ----------------------------------------------------------------------------
module pscnt_mod #(
  parameter int MODULUS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  value,
  output logic                         done,
  output logic [$clog2(MODULUS)-1:0]   rem
);
  localparam int SLOT_W = $clog2(MODULUS);
  localparam logic [31:0] MOD_W = 32'(MODULUS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MODULUS));

  logic [31:0]       val;
  logic [31:0]       quot;
  logic [31:0]       part;
  logic [63:0]       prod;
  logic [31:0]       back;
  logic              stage1;
  logic              stage2;
  logic              stage3;
  logic [SLOT_W-1:0] r;

  // The quotient estimate is exact or one short, so the partial remainder
  // lies below twice the modulus and one subtraction finishes it.
  always_comb begin
    prod = 64'(val) * 64'(RECIP);
    back = quot * MOD_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      stage3 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      stage3 <= stage2;
      done   <= stage3;
      if (start) begin
        val <= value;
      end
      if (stage1) begin
        quot <= prod[63:32];
      end
      if (stage2) begin
        part <= val - back;
      end
      if (stage3) begin
        r <= (part >= MOD_W) ? SLOT_W'(part - MOD_W) : SLOT_W'(part);
      end
    end
  end

  assign rem = r;
endmodule

// ===== test/tb_packet_statistics_counters.sv =====
// ----------------------------------------------------------------------------
// Packet statistics counters testbench
// Drives packet records and counter, window, peak and port reads through the
// request channel, predicts every read from a behavioural copy of the
// counters, ring buckets and port table, and checks each response in order.
// ----------------------------------------------------------------------------
module tb_packet_statistics_counters;
  import pscnt_pkg::*;

  localparam int WSEC = 64;

  typedef struct {
    logic [63:0] value;
    logic [63:0] pkts;
  } stat_rsp_t;

  class stats_scoreboard;
    logic [63:0] cnt [NUM_COUNTERS];
    logic [63:0] bkt_bytes [WSEC];
    logic [63:0] bkt_pkts [WSEC];
    logic [31:0] bkt_tag [WSEC];
    logic [31:0] newest;
    logic [63:0] port_bytes [int];
    stat_rsp_t pending [$];
    int errors;
    int reads_checked;

    function void clear();
      foreach (cnt[i]) cnt[i] = '0;
      for (int i = 0; i < WSEC; i++) begin
        bkt_bytes[i] = '0;
        bkt_pkts[i] = '0;
        bkt_tag[i] = '0;
      end
      newest = '0;
      port_bytes.delete();
      pending.delete();
      errors = 0;
      reads_checked = 0;
    endfunction

    function logic [63:0] port_entry(logic [15:0] p);
      return port_bytes.exists(p) ? port_bytes[p] : 64'd0;
    endfunction

    function void tally(logic [4:0] idx, logic [63:0] amount);
      cnt[idx] = cnt[idx] + amount;
    endfunction

    function void record(pscnt_desc_t d);
      int s;
      logic [63:0] len;
      logic [15:0] svc;
      len = {48'd0, d.wire_len};
      s = int'(d.ts_sec % 32'(WSEC));
      if (cnt[C_PKTS] == 0) cnt[C_FIRST] = {32'd0, d.ts_sec};
      cnt[C_LAST] = {32'd0, d.ts_sec};
      tally(C_PKTS, 64'd1);
      tally(C_BYTES, len);
      if (bkt_tag[s] != d.ts_sec) begin
        bkt_tag[s] = d.ts_sec;
        bkt_bytes[s] = '0;
        bkt_pkts[s] = '0;
      end
      if (d.ts_sec > newest) newest = d.ts_sec;
      bkt_bytes[s] = bkt_bytes[s] + len;
      bkt_pkts[s] = bkt_pkts[s] + 64'd1;
      if (d.status_flags[FLG_TRUNC]) tally(C_TRUNC, 64'd1);
      if (d.status_flags[FLG_BADCK]) tally(C_BADCK, 64'd1);
      if (d.status_flags[FLG_FRAG]) tally(C_FRAG, 64'd1);
      if (d.status_flags[FLG_DECERR]) begin
        tally(C_DECERR, 64'd1);
        return;
      end
      if (d.l3_kind == L3_IPV4) tally(C_IPV4, 64'd1);
      if (d.l3_kind == L3_IPV6) tally(C_IPV6, 64'd1);
      if (d.l3_kind == L3_ARP) begin
        tally(C_ARP_P, 64'd1);
        tally(C_ARP_B, len);
        return;
      end
      if (d.l4_kind == L4_TCP) begin
        tally(C_TCP_P, 64'd1);
        tally(C_TCP_B, len);
        if (d.tcp_flag_bits[TCP_SYN]) tally(C_SYN, 64'd1);
        if (d.tcp_flag_bits[TCP_FIN]) tally(C_FIN, 64'd1);
        if (d.tcp_flag_bits[TCP_RST]) tally(C_RST, 64'd1);
      end else if (d.l4_kind == L4_UDP) begin
        tally(C_UDP_P, 64'd1);
        tally(C_UDP_B, len);
      end else if (d.l4_kind == L4_ICMP || d.l4_kind == L4_ICMPV6) begin
        tally(C_ICMP_P, 64'd1);
        tally(C_ICMP_B, len);
      end else begin
        tally(C_OTH_P, 64'd1);
        tally(C_OTH_B, len);
      end
      if (d.status_flags[FLG_PORTS]) begin
        svc = (d.src_port < d.dst_port) ? d.src_port : d.dst_port;
        port_bytes[svc] = port_entry(svc) + len;
      end
    endfunction

    function stat_rsp_t window(logic [15:0] span);
      stat_rsp_t r;
      int n;
      logic [31:0] sec;
      int s;
      r.value = '0;
      r.pkts = '0;
      n = (span > 16'(WSEC)) ? WSEC : int'(span);
      if (span == 0 || newest == 0) return r;
      for (int i = 1; i <= n; i++) begin
        if (i > newest) break;
        sec = newest - 32'(i);
        s = int'(sec % 32'(WSEC));
        if (bkt_tag[s] == sec) begin
          r.value = r.value + bkt_bytes[s];
          r.pkts = r.pkts + bkt_pkts[s];
        end
      end
      return r;
    endfunction

    function void note_request(logic [2:0] op, pscnt_desc_t d);
      stat_rsp_t r;
      r.value = '0;
      r.pkts = '0;
      case (op)
        OP_RECORD: begin
          record(d);
          return;
        end
        OP_READ_CNT: r.value = (d.select < NUM_COUNTERS) ? cnt[d.select[4:0]] : 64'd0;
        OP_WINDOW: r = window(d.select);
        OP_PEAK: begin
          for (int i = 0; i < WSEC; i++)
            if (bkt_tag[i] != 0 && bkt_bytes[i] > r.value) r.value = bkt_bytes[i];
        end
        OP_PORT: r.value = port_entry(d.select);
        default: return;
      endcase
      pending = {pending, r};
    endfunction

    task check_response(logic [63:0] value, logic [63:0] pkts);
      stat_rsp_t e;
      if (pending.size() == 0) begin
        report("response with nothing expected", value, 64'd0);
        return;
      end
      e = pending.pop_front();
      reads_checked++;
      if (value !== e.value) report("read_value", value, e.value);
      if (pkts !== e.pkts) report("window_packets", pkts, e.pkts);
    endtask

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %h expected %h", what, got, want);
    endtask
  endclass

  logic clk;
  logic rst;
  pscnt_req_if req ();
  pscnt_rsp_if rsp ();
  stats_scoreboard sb;
  int send_idle;
  int recv_idle;
  int records_sent;
  int reads_sent;
  logic [31:0] base_sec;

  packet_statistics_counters #(.WINDOW_SECONDS(WSEC)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  initial begin
    #60000000;
    $display("tb_packet_statistics_counters failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      pscnt_desc_t d;
      d.ts_sec = req.ts_sec;
      d.wire_len = req.wire_len;
      d.status_flags = req.status_flags;
      d.l3_kind = req.l3_kind;
      d.l4_kind = req.l4_kind;
      d.tcp_flag_bits = req.tcp_flag_bits;
      d.src_port = req.src_port;
      d.dst_port = req.dst_port;
      d.select = req.select;
      sb.note_request(req.operation, d);
    end
    if (!rst && rsp.valid && rsp.ready) sb.check_response(rsp.read_value, rsp.window_packets);
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_request(logic [2:0] op, pscnt_desc_t d);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.ts_sec <= d.ts_sec;
    req.wire_len <= d.wire_len;
    req.status_flags <= d.status_flags;
    req.l3_kind <= d.l3_kind;
    req.l4_kind <= d.l4_kind;
    req.tcp_flag_bits <= d.tcp_flag_bits;
    req.src_port <= d.src_port;
    req.dst_port <= d.dst_port;
    req.select <= d.select;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    if (op == OP_RECORD) records_sent++;
    else reads_sent++;
  endtask

  function automatic pscnt_desc_t random_desc();
    pscnt_desc_t d;
    d.ts_sec = ($urandom_range(19) == 0) ? $urandom() : base_sec + $urandom_range(80);
    d.wire_len = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(1514, 40));
    if ($urandom_range(3) == 0) d.wire_len = 16'($urandom());
    d.status_flags = 5'($urandom());
    if ($urandom_range(1)) d.status_flags[FLG_DECERR] = 1'b0;
    d.l3_kind = 2'($urandom());
    d.l4_kind = 3'($urandom_range(7));
    d.tcp_flag_bits = 8'($urandom());
    d.src_port = ($urandom_range(1)) ? 16'($urandom_range(15)) : 16'($urandom());
    d.dst_port = ($urandom_range(1)) ? 16'($urandom_range(15)) : 16'($urandom());
    d.select = 16'($urandom());
    return d;
  endfunction

  task automatic send_random(int n);
    pscnt_desc_t d;
    int pick;
    for (int i = 0; i < n; i++) begin
      d = random_desc();
      pick = $urandom_range(99);
      if ($urandom_range(49) == 0) base_sec = base_sec + $urandom_range(200, 1);
      if (pick < 60) begin
        send_request(OP_RECORD, d);
      end else if (pick < 75) begin
        d.select = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(22));
        send_request(OP_READ_CNT, d);
      end else if (pick < 83) begin
        d.select = ($urandom_range(5) == 0) ? 16'($urandom()) : 16'($urandom_range(70));
        send_request(OP_WINDOW, d);
      end else if (pick < 88) begin
        send_request(OP_PEAK, d);
      end else if (pick < 97) begin
        d.select = ($urandom_range(1)) ? 16'($urandom_range(15)) : 16'($urandom());
        send_request(OP_PORT, d);
      end else begin
        send_request(3'($urandom_range(7, 5)), d);
      end
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic directed();
    pscnt_desc_t d;
    d = '0;
    send_request(OP_WINDOW, d);
    send_request(OP_PEAK, d);
    d.ts_sec = 32'd0;
    d.wire_len = 16'hFFFF;
    d.l3_kind = L3_IPV4;
    d.l4_kind = L4_TCP;
    d.tcp_flag_bits = 8'hFF;
    d.status_flags = 5'b10111;
    d.src_port = 16'hFFFF;
    d.dst_port = 16'd0;
    send_request(OP_RECORD, d);
    send_request(OP_PEAK, d);
    d.ts_sec = 32'hFFFF_FFFF;
    d.status_flags = 5'b01000;
    send_request(OP_RECORD, d);
    d.ts_sec = 32'd130;
    d.wire_len = 16'd0;
    d.status_flags = 5'b10000;
    d.l3_kind = L3_ARP;
    send_request(OP_RECORD, d);
    for (int k = 0; k < 8; k++) begin
      d.ts_sec = 32'd100 + 32'(k);
      d.wire_len = 16'(60 + k);
      d.l3_kind = L3_IPV6;
      d.l4_kind = 3'(k);
      d.src_port = 16'd80;
      d.dst_port = 16'd5000;
      send_request(OP_RECORD, d);
    end
    d.ts_sec = 32'd164;
    send_request(OP_RECORD, d);
    for (int k = 0; k < NUM_COUNTERS + 1; k += 3) begin
      d.select = 16'(k);
      send_request(OP_READ_CNT, d);
    end
    d.select = 16'hFFFF;
    send_request(OP_READ_CNT, d);
    send_request(OP_WINDOW, d);
    d.select = 16'd0;
    send_request(OP_WINDOW, d);
    send_request(OP_PORT, d);
    d.select = 16'd80;
    send_request(OP_PORT, d);
    send_request(3'd5, d);
    send_request(3'd7, d);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    sb = new();
    sb.clear();
    req.valid = 1'b0;
    req.operation = OP_RECORD;
    req.ts_sec = '0;
    req.wire_len = '0;
    req.status_flags = '0;
    req.l3_kind = '0;
    req.l4_kind = '0;
    req.tcp_flag_bits = '0;
    req.src_port = '0;
    req.dst_port = '0;
    req.select = '0;
    send_idle = 0;
    recv_idle = 0;
    records_sent = 0;
    reads_sent = 0;
    base_sec = 32'd1000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed();
    send_idle = 37;
    recv_idle = 86;
    send_random(500);
    send_idle = 86;
    recv_idle = 37;
    send_random(500);
    send_idle = 0;
    recv_idle = 0;
    send_random(525);
    drain();
    $display("Sent %0d packet records and %0d other requests; %0d read responses checked.",
             records_sent, reads_sent, sb.reads_checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_packet_statistics_counters passed");
    end else begin
      $display("tb_packet_statistics_counters failed");
    end
    $finish;
  end
endmodule
